[src/gregorian_date_step_unit_core_defines.svh]
// Assertion macros for the date step unit checker.
// Expects clk and rst_n in the scope of each use.
`ifndef GREGORIAN_DATE_STEP_UNIT_CORE_DEFINES_SVH
`define GREGORIAN_DATE_STEP_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define GDSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gdsu_pkg.sv]
// Shared types, codes and calendar helpers for the date step unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdsu_pkg;

  // operation codes
  localparam logic [2:0] OP_NEXT_DAY   = 3'd0;
  localparam logic [2:0] OP_PREV_DAY   = 3'd1;
  localparam logic [2:0] OP_NEXT_MONTH = 3'd2;
  localparam logic [2:0] OP_PREV_MONTH = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] yy;      // year shifted to a March start
    logic [7:0]  q_year;  // year / 100
    logic [7:0]  q_yy;    // yy / 100
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic [4:0]  mlen;
    logic        date_ok;
    logic [14:0] wsum;    // weekday congruence sum before mod 7
  } s2_t;

  // result item
  typedef struct packed {
    logic [13:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [2:0]  weekday;
    logic        leap_year;
    logic [4:0]  month_length;
    logic [1:0]  status;
  } res_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd2:                                     len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                  len = 5'd30;
    endcase
    return len;
  endfunction

  // floor(31 * mm / 12) for March-based month 1..12
  function automatic logic [4:0] month_term(input logic [3:0] mm);
    logic [4:0] t;
    unique case (mm)
      4'd1:    t = 5'd2;
      4'd2:    t = 5'd5;
      4'd3:    t = 5'd7;
      4'd4:    t = 5'd10;
      4'd5:    t = 5'd12;
      4'd6:    t = 5'd15;
      4'd7:    t = 5'd18;
      4'd8:    t = 5'd20;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd25;
      4'd11:   t = 5'd28;
      4'd12:   t = 5'd31;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[src/gdsu_front.sv]
// Stage 1: year shift and division by 100 via reciprocal multiply.
// Depends on gdsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  logic [2:0]        func,
  input  logic [13:0]       year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  output logic              vld_r,
  output gdsu_pkg::s1_t     data_r
);

  // y / 100 == (y * 5243) >> 19 for every 14-bit y
  localparam int unsigned RecipMul   = 5243;
  localparam int unsigned RecipShift = 19;

  logic [13:0]       yy;
  logic [26:0]       prod_year;
  logic [26:0]       prod_yy;
  gdsu_pkg::s1_t     data_nxt;

  always_comb begin
    yy        = year - {13'd0, (month <= 4'd2)};
    prod_year = {13'd0, year} * 27'(RecipMul);
    prod_yy   = {13'd0, yy} * 27'(RecipMul);
    data_nxt.func   = func;
    data_nxt.year   = year;
    data_nxt.month  = month;
    data_nxt.day    = day;
    data_nxt.yy     = yy;
    data_nxt.q_year = prod_year[RecipShift +: 8];
    data_nxt.q_yy   = prod_yy[RecipShift +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gdsu_calc.sv]
// Stage 2: leap year, month length, date check and weekday sum.
// Depends on gdsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdsu_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  gdsu_pkg::s1_t     data_in,
  output logic              vld_r,
  output gdsu_pkg::s2_t     data_r
);

  logic [14:0]       cent;
  logic              by100;
  logic              leap;
  logic [4:0]        mlen;
  logic [3:0]        mm;
  gdsu_pkg::s2_t     data_nxt;

  always_comb begin
    cent  = {7'd0, data_in.q_year} * 15'd100;
    by100 = ({1'b0, data_in.year} == cent);
    // divisible by 400: multiple of 100 with quotient a multiple of 4
    leap  = by100 ? (data_in.q_year[1:0] == 2'd0) : (data_in.year[1:0] == 2'd0);
    mlen  = gdsu_pkg::month_len(leap, data_in.month);
    mm    = (data_in.month <= 4'd2) ? data_in.month + 4'd10 : data_in.month - 4'd2;

    data_nxt.func    = data_in.func;
    data_nxt.year    = data_in.year;
    data_nxt.month   = data_in.month;
    data_nxt.day     = data_in.day;
    data_nxt.leap    = leap;
    data_nxt.mlen    = mlen;
    data_nxt.date_ok = (data_in.year >= gdsu_pkg::YEAR_MIN) &&
                       (data_in.year <= gdsu_pkg::YEAR_MAX) &&
                       (data_in.month >= 4'd1) && (data_in.month <= 4'd12) &&
                       (data_in.day >= 5'd1) && (data_in.day <= mlen);
    data_nxt.wsum    = {10'd0, data_in.day} + {1'd0, data_in.yy} +
                       {3'd0, data_in.yy[13:2]} - {7'd0, data_in.q_yy} +
                       {9'd0, data_in.q_yy[7:2]} +
                       {10'd0, gdsu_pkg::month_term(mm)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gdsu_step.sv]
// Stage 3: weekday mod 7, date step, range check, result register.
// Depends on gdsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdsu_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  gdsu_pkg::s2_t     data_in,
  output logic              vld_r,
  output gdsu_pkg::res_t    res_r
);

  logic [5:0]        fold1;
  logic [3:0]        fold2;
  logic [3:0]        fold3;
  logic [2:0]        wday;
  logic              wrap_up;
  logic              wrap_dn;
  logic [3:0]        mon_up;
  logic [3:0]        mon_dn;
  logic [13:0]       year_up;
  logic [13:0]       year_dn;
  logic [4:0]        len_up;
  logic [4:0]        len_dn;
  logic [13:0]       ny;
  logic [3:0]        nm;
  logic [4:0]        nd;
  gdsu_pkg::res_t    res_nxt;

  always_comb begin
    // 8 == 1 mod 7: fold 3-bit digits
    fold1 = {3'd0, data_in.wsum[2:0]} + {3'd0, data_in.wsum[5:3]} +
            {3'd0, data_in.wsum[8:6]} + {3'd0, data_in.wsum[11:9]} +
            {3'd0, data_in.wsum[14:12]};
    fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
    fold3 = {1'b0, fold2[2:0]} + {3'd0, fold2[3]};
    wday  = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];

    wrap_up = (data_in.month == 4'd12);
    wrap_dn = (data_in.month == 4'd1);
    mon_up  = wrap_up ? 4'd1 : data_in.month + 4'd1;
    mon_dn  = wrap_dn ? 4'd12 : data_in.month - 4'd1;
    year_up = data_in.year + 14'd1;
    year_dn = data_in.year - 14'd1;
    // a year change only lands in Dec or Jan, so February uses this year
    len_up  = gdsu_pkg::month_len(data_in.leap, mon_up);
    len_dn  = gdsu_pkg::month_len(data_in.leap, mon_dn);

    ny = data_in.year;
    nm = data_in.month;
    nd = data_in.day;
    unique case (data_in.func)
      gdsu_pkg::OP_NEXT_DAY: begin
        if (data_in.day == data_in.mlen) begin
          nd = 5'd1;
          nm = mon_up;
          ny = wrap_up ? year_up : data_in.year;
        end else begin
          nd = data_in.day + 5'd1;
        end
      end
      gdsu_pkg::OP_PREV_DAY: begin
        if (data_in.day == 5'd1) begin
          nm = mon_dn;
          ny = wrap_dn ? year_dn : data_in.year;
          nd = len_dn;
        end else begin
          nd = data_in.day - 5'd1;
        end
      end
      gdsu_pkg::OP_NEXT_MONTH: begin
        nm = mon_up;
        ny = wrap_up ? year_up : data_in.year;
        nd = (data_in.day > len_up) ? len_up : data_in.day;
      end
      gdsu_pkg::OP_PREV_MONTH: begin
        nm = mon_dn;
        ny = wrap_dn ? year_dn : data_in.year;
        nd = (data_in.day > len_dn) ? len_dn : data_in.day;
      end
      default: begin
        // query and unused codes: date passes through
      end
    endcase

    res_nxt.leap_year    = data_in.leap;
    res_nxt.month_length = data_in.mlen;
    res_nxt.new_year     = data_in.year;
    res_nxt.new_month    = data_in.month;
    res_nxt.new_day      = data_in.day;
    if (!data_in.date_ok) begin
      res_nxt.status  = gdsu_pkg::STATUS_INVALID;
      res_nxt.weekday = 3'd0;
    end else if ((ny < gdsu_pkg::YEAR_MIN) || (ny > gdsu_pkg::YEAR_MAX)) begin
      res_nxt.status  = gdsu_pkg::STATUS_RANGE;
      res_nxt.weekday = wday;
    end else begin
      res_nxt.status    = gdsu_pkg::STATUS_OK;
      res_nxt.weekday   = wday;
      res_nxt.new_year  = ny;
      res_nxt.new_month = nm;
      res_nxt.new_day   = nd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gregorian_date_step_unit_core.sv]
// Gregorian date step unit. Each request carries a date (year, month, day)
// and an operation: next day, previous day, next month, previous month or
// query (codes 5 to 7 behave as query). Month steps clamp the day to the
// length of the new month. Every request yields exactly one result holding
// the stepped date plus the weekday (0 = Sunday), leap flag and month
// length of the input date. An invalid input date returns status 1 with
// the date unchanged and weekday 0; a step past year 1 or 9999 returns
// status 2 with the date unchanged. A new request is taken every cycle
// while in_stall is low. The unit is a three-stage pipeline (reciprocal
// divide by 100, calendar checks and weekday sum, then mod 7 and the step
// itself) in which each stage moves whenever the stage after it is empty
// or moving, so in_stall only rises once all three stages hold requests
// and the result is stalled. Depends on gdsu_pkg and the three stage
// modules.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_step_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_new_year,
  output logic [3:0]  out_new_month,
  output logic [4:0]  out_new_day,
  output logic [2:0]  out_weekday,
  output logic        out_leap_year,
  output logic [4:0]  out_month_length,
  output logic [1:0]  out_status
);

  logic              s1_vld;
  logic              s2_vld;
  logic              s3_vld;
  logic              en1;
  logic              en2;
  logic              en3;
  gdsu_pkg::s1_t     s1_data;
  gdsu_pkg::s2_t     s2_data;
  gdsu_pkg::res_t    res;

  // A stage loads when its own slot is free or its occupant moves on.
  assign en3      = !s3_vld || !out_stall;
  assign en2      = !s2_vld || en3;
  assign en1      = !s1_vld || en2;
  assign in_stall = !en1;

  gdsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en1),
    .vld_in (in_valid),
    .func   (in_func),
    .year   (in_year),
    .month  (in_month),
    .day    (in_day),
    .vld_r  (s1_vld),
    .data_r (s1_data)
  );

  gdsu_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .vld_in  (s1_vld),
    .data_in (s1_data),
    .vld_r   (s2_vld),
    .data_r  (s2_data)
  );

  gdsu_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .vld_in  (s2_vld),
    .data_in (s2_data),
    .vld_r   (s3_vld),
    .res_r   (res)
  );

  // Output register is the last pipeline stage.
  assign out_valid        = s3_vld;
  assign out_new_year     = res.new_year;
  assign out_new_month    = res.new_month;
  assign out_new_day      = res.new_day;
  assign out_weekday      = res.weekday;
  assign out_leap_year    = res.leap_year;
  assign out_month_length = res.month_length;
  assign out_status       = res.status;

endmodule

`default_nettype wire

[src/gdsu_checker.sv]
// Port-level checks for the date step unit, bound to the top level.
// Depends on gdsu_pkg and gregorian_date_step_unit_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "gregorian_date_step_unit_core_defines.svh"

module gdsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_new_year,
  input logic [3:0]  out_new_month,
  input logic [4:0]  out_new_day,
  input logic [2:0]  out_weekday,
  input logic        out_leap_year,
  input logic [4:0]  out_month_length,
  input logic [1:0]  out_status
);

  logic [33:0] payload;
  logic        ok_date;
  logic        res_held;
  logic        res_ok;
  logic        res_bad;
  logic        fields_ok;

  assign payload = {out_new_year, out_new_month, out_new_day, out_weekday,
                    out_leap_year, out_month_length, out_status};
  assign ok_date = (out_new_year >= gdsu_pkg::YEAR_MIN) &&
                   (out_new_year <= gdsu_pkg::YEAR_MAX) &&
                   (out_new_month >= 4'd1) && (out_new_month <= 4'd12) &&
                   (out_new_day >= 5'd1) && (out_weekday <= 3'd6);
  assign res_held  = out_valid && out_stall;
  assign res_ok    = out_valid && (out_status == gdsu_pkg::STATUS_OK);
  assign res_bad   = out_valid && (out_status == gdsu_pkg::STATUS_INVALID);
  assign fields_ok = (out_month_length >= 5'd28) && (out_month_length <= 5'd31) &&
                     (out_status <= gdsu_pkg::STATUS_RANGE);

  `GDSU_ASSERT_NEXT(a_out_hold, res_held, out_valid && $stable(payload), "stalled result changed")
  `GDSU_ASSERT_NOW(a_ok_date, res_ok, ok_date, "ok result carries an impossible date")
  `GDSU_ASSERT_NOW(a_bad_wday, res_bad, out_weekday == 3'd0, "invalid date must report weekday 0")
  `GDSU_ASSERT_NOW(a_mlen, out_valid, fields_ok, "month length or status out of range")

endmodule

bind gregorian_date_step_unit_core gdsu_checker u_gdsu_checker (.*);

`default_nettype wire

[dv/date_check_pkg.sv]
// Calendar predictor and result scoreboard for the date step unit bench.
// Depends on gdsu_pkg for operation/status codes and the result type.
`timescale 1ns / 1ps

package date_check_pkg;

  import gdsu_pkg::*;

  // spare operation codes, all behave as a query
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_req_t;

  function automatic bit gregorian_leap(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:                     return gregorian_leap(y) ? 29 : 28;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:               return 30;
    endcase
  endfunction

  // Zeller-style congruence with the year starting in March
  function automatic int unsigned weekday_of(int unsigned y, int unsigned m, int unsigned d);
    int unsigned jan_feb;
    int unsigned yy;
    int unsigned mm;
    jan_feb = (m <= 2) ? 1 : 0;
    yy = y - jan_feb;
    mm = m + 12 * jan_feb - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic res_t step_date(date_req_t r);
    res_t        e;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    int unsigned ny;
    int unsigned nm;
    int unsigned nd;
    y   = r.year;
    m   = r.month;
    d   = r.day;
    len = month_days(y, m);
    ny  = y;
    nm  = m;
    nd  = d;
    e.weekday      = '0;
    e.status       = STATUS_OK;
    e.leap_year    = gregorian_leap(y);
    e.month_length = 5'(len);
    if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12 || d < 1 || d > len) begin
      e.status = STATUS_INVALID;
    end else begin
      e.weekday = 3'(weekday_of(y, m, d));
      case (r.func)
        OP_NEXT_DAY: begin
          if (d == len) begin
            nd = 1;
            if (m == 12) begin
              nm = 1;
              ny = y + 1;
            end else begin
              nm = m + 1;
            end
          end else begin
            nd = d + 1;
          end
        end
        OP_PREV_DAY: begin
          if (d == 1) begin
            if (m == 1) begin
              nm = 12;
              ny = y - 1;
            end else begin
              nm = m - 1;
            end
            nd = month_days(ny, nm);
          end else begin
            nd = d - 1;
          end
        end
        OP_NEXT_MONTH, OP_PREV_MONTH: begin
          if (r.func == OP_NEXT_MONTH) begin
            if (m == 12) begin
              nm = 1;
              ny = y + 1;
            end else begin
              nm = m + 1;
            end
          end else begin
            if (m == 1) begin
              nm = 12;
              ny = y - 1;
            end else begin
              nm = m - 1;
            end
          end
          if (nd > month_days(ny, nm)) nd = month_days(ny, nm);
        end
        default: ;
      endcase
      if (ny < YEAR_MIN || ny > YEAR_MAX) begin
        e.status = STATUS_RANGE;
        ny = y;
        nm = m;
        nd = d;
      end
    end
    e.new_year  = 14'(ny);
    e.new_month = 4'(nm);
    e.new_day   = 5'(nd);
    return e;
  endfunction

  class date_step_scoreboard;
    res_t        expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned op_seen[8];
    int unsigned status_seen[4];

    function void note_request(date_req_t r);
      op_seen[r.func]++;
      expected_q.push_back(step_date(r));
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[want.status]++;
      compare_field("new_year", want.new_year, got.new_year);
      compare_field("new_month", want.new_month, got.new_month);
      compare_field("new_day", want.new_day, got.new_day);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("leap_year", want.leap_year, got.leap_year);
      compare_field("month_length", want.month_length, got.month_length);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
// Top-level bench for gregorian_date_step_unit_core: directed and random requests.
// Depends on gdsu_pkg, date_check_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;

  import gdsu_pkg::*;
  import date_check_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned QUIET_LIMIT     = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_CYCLES = 80;    // long receiver stall to fill the pipe
  localparam int unsigned SQUEEZE_FIRST   = 400;   // random request index where it starts
  localparam int unsigned SQUEEZE_LEN     = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [13:0] in_year = '0;
  logic [3:0]  in_month = '0;
  logic [4:0]  in_day = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_new_year;
  logic [3:0]  out_new_month;
  logic [4:0]  out_new_day;
  logic [2:0]  out_weekday;
  logic        out_leap_year;
  logic [4:0]  out_month_length;
  logic [1:0]  out_status;

  date_step_scoreboard sb;
  bit          squeeze = 1'b0;   // sender is streaming gap-free; receiver holds off once
  int unsigned quiet_cycles = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gregorian_date_step_unit_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_year     (out_new_year),
    .out_new_month    (out_new_month),
    .out_new_day      (out_new_day),
    .out_weekday      (out_weekday),
    .out_leap_year    (out_leap_year),
    .out_month_length (out_month_length),
    .out_status       (out_status)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Years biased toward the range ends and the century/leap boundaries.
  function automatic int unsigned pick_year();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(9996, 9999);
      2, 3:    return 100 * $urandom_range(1, 99);
      4:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // Mostly well-formed dates with random operations; the rest is raw noise
  // or dates with a bad month/day.
  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned sel;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned k;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      r.func  = 3'($urandom);
      r.year  = 14'($urandom);
      r.month = 4'($urandom);
      r.day   = 5'($urandom);
      return r;
    end
    y = pick_year();
    m = ($urandom_range(0, 9) < 3) ? (($urandom_range(0, 1) == 1) ? 12 : 1)
                                   : $urandom_range(1, 12);
    len = month_days(y, m);
    k = $urandom_range(0, 19);
    r.func = (k < 17) ? 3'(k % 5) : 3'($urandom_range(5, 7));
    r.year = 14'(y);
    if (sel < 16) begin
      // broken date: month or day out of its range (some land valid anyway)
      r.month = ($urandom_range(0, 1) == 1) ? 4'($urandom) : 4'(m);
      r.day   = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
      return r;
    end
    r.month = 4'(m);
    case ($urandom_range(0, 9))
      0, 1, 2: r.day = 5'(len);
      3, 4:    r.day = 5'd1;
      5:       r.day = 5'(len - $urandom_range(1, 2));
      default: r.day = 5'($urandom_range(1, len));
    endcase
    return r;
  endfunction

  // Offer one request after an optional idle gap; returns at the falling
  // edge after acceptance so back-to-back requests keep in_valid high.
  task automatic send_date(input date_req_t r, input int unsigned gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func  = r.func;
    in_year  = r.year;
    in_month = r.month;
    in_day   = r.day;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Result monitor: every accepted result goes against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_new_year, out_new_month, out_new_day, out_weekday,
                        out_leap_year, out_month_length, out_status});
  end

  // Watchdog: a run of cycles with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles at %0t", QUIET_LIMIT, $time);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: calm stretches with no stall, random stall runs otherwise, and
  // one long hold-off while the sender streams so the pipeline backs up.
  initial begin : result_side
    int unsigned cyc;
    int unsigned run;
    bit          held;
    cyc  = 0;
    run  = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (squeeze && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (run > 0) begin
        out_stall = 1'b1;
        run--;
      end else if (cyc % 200 < 50) begin
        out_stall = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        run = pick_gap();
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Directed requests: range ends, all operations, spare codes, clamping,
  // leap rules and every flavor of invalid date.
  date_req_t directed[25];

  initial begin : request_side
    int unsigned gap;
    sb = new;
    directed = '{
      {OP_NEXT_DAY,   14'd2023,  4'd12, 5'd31},  // year rollover
      {OP_NEXT_DAY,   14'd9999,  4'd12, 5'd31},  // past the last year
      {OP_PREV_DAY,   14'd1,     4'd1,  5'd1},   // before the first year
      {OP_PREV_DAY,   14'd2024,  4'd3,  5'd1},   // back into Feb 29
      {OP_PREV_DAY,   14'd1900,  4'd3,  5'd1},   // century, not leap
      {OP_PREV_DAY,   14'd2000,  4'd1,  5'd1},
      {OP_NEXT_MONTH, 14'd2000,  4'd1,  5'd31},  // clamp to 29
      {OP_NEXT_MONTH, 14'd2100,  4'd1,  5'd30},  // clamp to 28
      {OP_NEXT_MONTH, 14'd9999,  4'd12, 5'd15},
      {OP_PREV_MONTH, 14'd1,     4'd1,  5'd20},
      {OP_PREV_MONTH, 14'd2023,  4'd3,  5'd31},
      {OP_PREV_MONTH, 14'd500,   4'd1,  5'd31},
      {OP_QUERY,      14'd2000,  4'd2,  5'd29},
      {OP_QUERY,      14'd1900,  4'd2,  5'd29},  // Feb 29 in a non-leap year
      {OP_SPARE_5,    14'd1,     4'd1,  5'd1},
      {OP_SPARE_6,    14'd9999,  4'd12, 5'd31},
      {OP_SPARE_7,    14'd2024,  4'd7,  5'd4},
      {OP_NEXT_DAY,   14'd0,     4'd6,  5'd15},  // year zero: invalid, still leap
      {OP_QUERY,      14'd16383, 4'd15, 5'd31},  // all ones
      {OP_NEXT_DAY,   14'd2024,  4'd0,  5'd0},
      {OP_PREV_DAY,   14'd2024,  4'd13, 5'd5},   // bad month, length 30
      {OP_NEXT_DAY,   14'd2024,  4'd4,  5'd31},  // day past a 30-day month
      {OP_NEXT_DAY,   14'd2024,  4'd2,  5'd28},
      {OP_NEXT_MONTH, 14'd1234,  4'd5,  5'd0},
      {OP_NEXT_DAY,   14'd10000, 4'd1,  5'd1}
    };

    // synchronous reset, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_date(directed[i], pick_gap());

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      // squeeze window: stream gap-free while the receiver holds off
      squeeze = (n >= SQUEEZE_FIRST && n < SQUEEZE_FIRST + SQUEEZE_LEN);
      gap = (squeeze || n % 128 < 32) ? 0 : pick_gap();
      send_date(random_request(), gap);
    end
    squeeze  = 1'b0;
    in_valid = 1'b0;

    // drain, then keep waiting to catch any stray result
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb_top: %0d results checked: %0d ok, %0d invalid date, %0d year out of range",
             sb.checked, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_INVALID],
             sb.status_seen[STATUS_RANGE]);
    $display("tb_top: ops next/prev day %0d/%0d, next/prev month %0d/%0d, query %0d, spare %0d",
             sb.op_seen[OP_NEXT_DAY], sb.op_seen[OP_PREV_DAY], sb.op_seen[OP_NEXT_MONTH],
             sb.op_seen[OP_PREV_MONTH], sb.op_seen[OP_QUERY],
             sb.op_seen[OP_SPARE_5] + sb.op_seen[OP_SPARE_6] + sb.op_seen[OP_SPARE_7]);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/gdsu_pkg.sv
src/gdsu_front.sv
src/gdsu_calc.sv
src/gdsu_step.sv
src/gregorian_date_step_unit_core.sv
src/gdsu_checker.sv
dv/date_check_pkg.sv
dv/tb_top.sv
